@@ rtl/core/modexp_pkg.sv @@
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

    localparam int DATA_BITS_DEF = 64;
    localparam int BASE_W        = 64;
    localparam int EXP_W         = 63;
    localparam int MOD_W         = 63;
    localparam int RES_W         = 63;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MUL,
        S_SQR,
        S_NEXT,
        S_DONE
    } t_state;

    // Control word from the sequencer to the cell chain.
    typedef struct packed {
        logic load;  // Clear the chain and load operands.
        logic run;   // Advance the chain by one step.
    } t_chain_ctl;

endpackage

@@ rtl/core/modexp_cell.sv @@
// One bit cell of the modular accumulator: add slice, modulus borrow slice and state bit.
module modexp_cell (
    input  logic i_clk,
    input  logic i_load,
    input  logic i_en,
    input  logic i_dbl_bit,   // Doubled and reduced accumulator bit at this position.
    input  logic i_add_bit,   // Addend bit at this position.
    input  logic i_sub_bit,   // Modulus bit at this position.
    input  logic i_cin,
    input  logic i_bin,
    input  logic i_take_diff, // The sum reached the modulus, so keep the difference.
    output logic o_acc,
    output logic o_cout,
    output logic o_bout
);
    logic r_acc;
    logic n_acc;
    logic s;
    logic d;

    // Adder slice for acc + addend, followed by borrow slice of that sum - modulus.
    assign s      = i_dbl_bit ^ i_add_bit ^ i_cin;
    assign o_cout = (i_dbl_bit & i_add_bit) | (i_cin & (i_dbl_bit ^ i_add_bit));
    assign d      = s ^ i_sub_bit ^ i_bin;
    assign o_bout = (~s & i_sub_bit) | (i_bin & ~(s ^ i_sub_bit));
    assign o_acc  = r_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_load) begin
            n_acc = 1'b0;
        end else if (i_en) begin
            n_acc = i_take_diff ? d : s;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end
endmodule

@@ rtl/core/modexp_chain.sv @@
// Row of bit cells forming a shift-add modular multiplier, one multiplier bit per step.
module modexp_chain #(
    parameter int W = modexp_pkg::DATA_BITS_DEF
) (
    input  logic                   i_clk,
    input  modexp_pkg::t_chain_ctl i_ctl,
    input  logic [W-1:0]           i_a,
    input  logic [W-1:0]           i_b,
    input  logic [W-1:0]           i_m,
    output logic [W-1:0]           o_prod,
    output logic                   o_done
);
    import modexp_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_b;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  cell_acc;
    logic [W:0]    dbl;
    logic [W-1:0]  dbl_red;
    logic [W-1:0]  addend;
    logic [W:0]    carry;
    logic [W:0]    borrow;
    logic          take_diff;
    logic          step;

    // Doubling with its own reduction feeds the cells; acc stays below m.
    assign dbl       = {cell_acc, 1'b0};
    assign dbl_red   = (dbl >= {1'b0, i_m}) ? W'(dbl - {1'b0, i_m}) : dbl[W-1:0];
    assign addend    = r_b[W-1] ? i_a : '0;
    assign carry[0]  = 1'b0;
    assign borrow[0] = 1'b0;
    // The sum reaches m when it carries out or when subtracting m leaves no borrow.
    assign take_diff = carry[W] | ~borrow[W];
    assign step      = i_ctl.run && (r_cnt != '0);

    for (genvar g = 0; g < W; g++) begin : g_cell
        modexp_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (i_ctl.load),
            .i_en       (step),
            .i_dbl_bit  (dbl_red[g]),
            .i_add_bit  (addend[g]),
            .i_sub_bit  (i_m[g]),
            .i_cin      (carry[g]),
            .i_bin      (borrow[g]),
            .i_take_diff(take_diff),
            .o_acc      (cell_acc[g]),
            .o_cout     (carry[g+1]),
            .o_bout     (borrow[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_b   <= i_b;
            r_cnt <= CW'(W);
        end else if (step) begin
            r_b   <= r_b << 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_prod = cell_acc;
    assign o_done = (r_cnt == '0);
endmodule

@@ rtl/core/modexp_reduce.sv @@
// Bit-serial restoring remainder of the base magnitude by the modulus.
module modexp_reduce #(
    parameter int W = modexp_pkg::DATA_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic [W-1:0] i_mag,
    input  logic [W-1:0] i_m,
    output logic [W-1:0] o_rem,
    output logic         o_done
);
    import modexp_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_q;
    logic [CW-1:0] r_cnt;
    logic [W:0]    sh;

    assign sh = {r_rem, r_q[W-1]};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_q   <= i_mag;
            r_cnt <= CW'(W);
        end else if (r_cnt != '0) begin
            r_rem <= (sh >= {1'b0, i_m}) ? W'(sh - {1'b0, i_m}) : sh[W-1:0];
            r_q   <= r_q << 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rem  = r_rem;
    assign o_done = (r_cnt == '0);
endmodule

@@ rtl/core/modular_exponentiation_top.sv @@
// Top level: square-and-multiply sequencer around the shift-add cell chain.
// Sequence: base reduction, then per exponent bit an optional multiply and a square
// on the cell chain plus a step state, then the result strobe.
// One transaction at a time; busy is high from acceptance until the result strobe.
// Synchronous active-low reset returns the sequencer to idle; the receiver cannot stall.
module modular_exponentiation_top #(
    parameter int DATA_BITS = modexp_pkg::DATA_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [modexp_pkg::BASE_W-1:0]   i_base_value,
    input  logic [modexp_pkg::EXP_W-1:0]    i_exponent,
    input  logic [modexp_pkg::MOD_W-1:0]    i_modulus,
    output logic                            o_valid,
    output logic [modexp_pkg::RES_W-1:0]    o_power_residue
);
    import modexp_pkg::*;

    localparam int W = DATA_BITS;

    t_state r_state, n_state;
    logic [W-1:0] r_base, r_acc, r_m, r_e;
    logic [W-1:0] raw, mag;
    logic         r_neg;
    logic         r_first;
    t_chain_ctl   ctl;
    logic [W-1:0] ma, mb, prod, rem;
    logic         mdone, rdone, rload;
    logic [W-1:0] m_in;

    assign raw  = i_base_value[W-1:0];
    assign mag  = raw[W-1] ? W'(-raw) : raw;
    assign m_in = {1'b0, i_modulus[W-2:0]};

    modexp_reduce #(.W(W)) u_red (
        .i_clk(i_clk), .i_load(rload), .i_mag(mag), .i_m(r_m),
        .o_rem(rem), .o_done(rdone)
    );

    modexp_chain #(.W(W)) u_chain (
        .i_clk(i_clk), .i_ctl(ctl), .i_a(ma), .i_b(mb), .i_m(r_m),
        .o_prod(prod), .o_done(mdone)
    );

    assign rload = start && !busy;
    assign ma = r_state == S_SQR ? r_base : r_acc;
    assign mb = r_base;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = S_REDUCE;
            S_REDUCE: if (rdone && !r_first) begin
                if (r_m <= W'(1)) n_state = S_DONE;
                else if (r_e == '0) n_state = S_DONE;
                else n_state = r_e[0] ? S_MUL : S_SQR;
            end
            S_MUL:    if (mdone && !r_first) n_state = S_SQR;
            S_SQR:    if (mdone && !r_first) n_state = S_NEXT;
            S_NEXT:   n_state = (r_e == '0) ? S_DONE : (r_e[0] ? S_MUL : S_SQR);
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctl.load = 1'b0;
        ctl.run  = 1'b0;
        case (r_state)
            S_MUL, S_SQR: begin
                ctl.load = r_first;
                ctl.run  = !r_first;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= (n_state != r_state) || (r_state == S_IDLE && start);
        end
        case (r_state)
            S_IDLE: if (start) begin
                r_m   <= m_in;
                r_e   <= {1'b0, i_exponent[W-2:0]};
                r_neg <= raw[W-1];
                r_acc <= W'(1);
            end
            S_REDUCE: if (rdone && !r_first) begin
                r_base <= (r_neg && rem != '0) ? r_m - rem : rem;
            end
            S_MUL: if (mdone && !r_first) r_acc <= prod;
            S_SQR: if (mdone && !r_first) begin
                r_base <= prod;
                r_e    <= r_e >> 1;
            end
            default: ;
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_DONE);
    assign o_power_residue = (r_m <= W'(1)) ? '0 : RES_W'(r_acc);
endmodule

@@ rtl/core/modexp_checker.sv @@
// Port-level checker for the modular exponentiation top level, with its bind.
module modexp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [62:0] o_power_residue
);
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe too long");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("strobe outside transaction");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("busy stuck");
    a_residue_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_power_residue)) else $error("unknown residue");
endmodule

bind modular_exponentiation_top modexp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_power_residue(o_power_residue)
);

@@ test/tb_top.sv @@
// Testbench for the modular exponentiation block: random and directed operands, scoreboarded.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import modexp_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam int N_RANDOM    = 100;
    localparam logic [62:0] MAX63 = {63{1'b1}};

    // Expected residues, oldest first, with a check on each strobe.
    class residue_board;
        logic [RES_W-1:0] pending[$];
        int               n_errors;

        function new();
            n_errors = 0;
        endfunction

        // Square-and-multiply prediction at full 64-bit width.
        function void note_request(logic [BASE_W-1:0] b_in, logic [EXP_W-1:0] e_in,
                                   logic [MOD_W-1:0] m_in);
            logic [63:0]  mag;
            logic [63:0]  b;
            logic [63:0]  acc;
            logic [62:0]  e;
            logic [127:0] prod;
            e = e_in;
            if (m_in <= 1) begin
                pending.push_back('0);
                return;
            end
            mag = b_in[63] ? (~b_in + 64'd1) : b_in;
            b = mag % {1'b0, m_in};
            if (b_in[63] && b != 0) b = {1'b0, m_in} - b;
            acc = 64'd1;
            while (e != 0) begin
                if (e[0]) begin
                    prod = {64'd0, acc} * {64'd0, b};
                    acc = 64'(prod % {65'd0, m_in});
                end
                e = e >> 1;
                prod = {64'd0, b} * {64'd0, b};
                b = 64'(prod % {65'd0, m_in});
            end
            pending.push_back(acc[62:0]);
        endfunction

        function void check_residue(logic [RES_W-1:0] got);
            logic [RES_W-1:0] want;
            if (pending.size() == 0) begin
                $error("power_residue: unexpected result %0d", got);
                n_errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $error("power_residue: expected %0d, actual %0d", want, got);
                n_errors++;
            end
        endfunction
    endclass

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             start = 0;
    logic             busy;
    logic [BASE_W-1:0] i_base_value = '0;
    logic [EXP_W-1:0]  i_exponent = '0;
    logic [MOD_W-1:0]  i_modulus = '0;
    logic             o_valid;
    logic [RES_W-1:0] o_power_residue;

    residue_board board = new();
    int idle_pct = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    modular_exponentiation_top dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_residue(o_power_residue);
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Presents one request and holds it until it is taken.
    task automatic send_request(logic [63:0] b, logic [62:0] e, logic [62:0] m);
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        start        <= 1'b1;
        i_base_value <= b;
        i_exponent   <= e;
        i_modulus    <= m;
        do @(posedge i_clk); while (busy);
        board.note_request(b, e, m);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly short exponents keep the run fast; a few use every bit.
    task automatic send_random();
        logic [62:0] e;
        logic [62:0] m;
        int          pick;
        pick = $urandom_range(9);
        e = 63'(rand64());
        if (pick < 7) e = e & 63'hFFF;
        m = 63'(rand64());
        if ($urandom_range(7) == 0) m = m & 63'h3F;
        send_request(rand64(), e, m);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corner cases.
        send_request(64'd7, 63'd5, 63'd1);
        send_request(64'd7, 63'd5, 63'd0);
        send_request(64'd12, 63'd0, 63'd13);
        send_request(-64'sd1, 63'd1, 63'd5);
        send_request(-64'sd1, 63'd3, 63'd5);
        send_request(64'h8000_0000_0000_0000, 63'd1, MAX63);
        send_request(64'h7FFF_FFFF_FFFF_FFFF, MAX63, MAX63);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, MAX63, MAX63 - 1);
        send_request(64'd0, 63'd0, 63'd2);
        send_request(64'd0, 63'd9, 63'd97);
        send_request(64'd2, 63'd62, MAX63);
        send_request(-64'sd10, 63'd2, 63'd10);
        send_request(64'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAB);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 63'h5555_5555_5555_5555);
        drain();

        idle_pct = 7;
        repeat (N_RANDOM / 3) send_random();
        drain();
        idle_pct = 81;
        repeat (N_RANDOM / 3) send_random();
        idle_pct = 0;
        repeat (N_RANDOM / 3) send_random();

        drain();
        repeat (20) @(posedge i_clk);
        if (board.n_errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
